>>> design/cc_pkg.sv
package cc_pkg;

	localparam int W_EL   = 32;
	localparam int QF     = 16;
	localparam int W_PROD = 2 * W_EL;
	localparam int W_MIN  = W_PROD + 1;
	localparam int W_PART = W_MIN;
	localparam int W_TRI  = W_MIN + W_EL;
	localparam int W_DET  = W_TRI + 3;
	localparam int W_REM  = W_DET + W_EL;
	localparam int QBITS  = W_EL;

	typedef logic signed [W_EL-1:0]   elem_t;
	typedef elem_t                    mat_t [3][4];
	typedef logic signed [W_PROD-1:0] prod_t;
	typedef logic signed [W_MIN-1:0]  minor_t;
	typedef logic signed [W_PART-1:0] part_t;
	typedef logic signed [W_TRI-1:0]  tri_t;
	typedef logic signed [W_DET-1:0]  det_t;
	typedef logic [W_REM-1:0]         rem_t;
	typedef logic [QBITS-1:0]         quo_t;

	localparam quo_t SAT_MAX = {1'b0, {(QBITS-1){1'b1}}};
	localparam quo_t SAT_MIN = {1'b1, {(QBITS-1){1'b0}}};

	// rows left over when row r is struck out
	localparam int RA [3] = '{1, 0, 0};
	localparam int RB [3] = '{2, 2, 1};
	// column pairs (1,2) (1,3) (2,3)
	localparam int PJ [3] = '{1, 1, 2};
	localparam int PK [3] = '{2, 3, 3};
	// x y z t: expansion column, column pair, negate
	localparam int   DCA  [4] = '{1, 0, 0, 0};
	localparam int   DPR  [4] = '{2, 2, 1, 0};
	localparam logic DNEG [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

endpackage

>>> design/camera_center_from_projection.sv
// throughput: one matrix per cycle; the whole pipeline holds while the
// result word waits, and bubbles pass through as empty stages
// the radix-2 divider, with its 32 quotient-bit stages, sets the depth
// reset clears only the stage valid bits
module camera_center_from_projection import cc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] p00,
	input  logic [31:0] p01,
	input  logic [31:0] p02,
	input  logic [31:0] p03,
	input  logic [31:0] p10,
	input  logic [31:0] p11,
	input  logic [31:0] p12,
	input  logic [31:0] p13,
	input  logic [31:0] p20,
	input  logic [31:0] p21,
	input  logic [31:0] p22,
	input  logic [31:0] p23,
	output logic        center_valid,
	input  logic        center_ready,
	output logic [31:0] center_x,
	output logic [31:0] center_y,
	output logic [31:0] center_z,
	output logic        at_infinity
);

	logic   en;
	mat_t   m;
	logic   mv;
	mat_t   el;
	minor_t mn [3][3];
	logic   dv;
	det_t   dt [4];
	det_t   num [3];
	quo_t   q [3];

	assign en         = !center_valid || center_ready;
	assign item_ready = en;

	assign m[0][0] = signed'(p00);
	assign m[0][1] = signed'(p01);
	assign m[0][2] = signed'(p02);
	assign m[0][3] = signed'(p03);
	assign m[1][0] = signed'(p10);
	assign m[1][1] = signed'(p11);
	assign m[1][2] = signed'(p12);
	assign m[1][3] = signed'(p13);
	assign m[2][0] = signed'(p20);
	assign m[2][1] = signed'(p21);
	assign m[2][2] = signed'(p22);
	assign m[2][3] = signed'(p23);

	cc_minor u_minor (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (item_valid),
		.m      (m),
		.out_v  (mv),
		.el     (el),
		.mn     (mn)
	);

	cc_det u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (mv),
		.el     (el),
		.mn     (mn),
		.out_v  (dv),
		.dt     (dt)
	);

	assign num[0] = dt[0];
	assign num[1] = dt[1];
	assign num[2] = dt[2];

	cc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (dv),
		.num    (num),
		.den    (dt[3]),
		.out_v  (center_valid),
		.q      (q),
		.zero   (at_infinity)
	);

	assign center_x = q[0];
	assign center_y = q[1];
	assign center_z = q[2];

`ifndef SYNTHESIS
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		center_valid && at_infinity |-> center_x == '0 && center_y == '0 && center_z == '0)
		else $error("nonzero center at infinity");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		center_valid && !center_ready |-> !item_ready)
		else $error("word taken while output stalled");

	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		!center_valid |-> item_ready)
		else $error("pipeline held with empty output");
`endif

endmodule

>>> design/cc_minor.sv
module cc_minor import cc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_v,
	input  mat_t   m,
	output logic   out_v,
	output mat_t   el,
	output minor_t mn [3][3]
);

	logic   v_s1, v_s2;
	mat_t   el_s1, el_s2;
	prod_t  pa_s1 [3][3];
	prod_t  pb_s1 [3][3];
	minor_t mn_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			el_s1 <= m;
			el_s2 <= el_s1;
			for (int r = 0; r < 3; r++) begin
				for (int p = 0; p < 3; p++) begin
					pa_s1[r][p] <= m[RA[r]][PJ[p]] * m[RB[r]][PK[p]];
					pb_s1[r][p] <= m[RA[r]][PK[p]] * m[RB[r]][PJ[p]];
					mn_s2[r][p] <= minor_t'(pa_s1[r][p]) - minor_t'(pb_s1[r][p]);
				end
			end
		end
	end

	assign out_v = v_s2;
	assign el    = el_s2;
	assign mn    = mn_s2;

endmodule

>>> design/cc_det.sv
module cc_det import cc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_v,
	input  mat_t   el,
	input  minor_t mn [3][3],
	output logic   out_v,
	output det_t   dt [4]
);

	logic               v_s3, v_s4, v_s5;
	logic signed [32:0] lo_c [4][3];
	logic signed [32:0] hi_c [4][3];
	elem_t              e_c  [4][3];
	part_t              pl_s3 [4][3];
	part_t              ph_s3 [4][3];
	tri_t               tp_s4 [4][3];
	det_t               sum_c [4];
	det_t               dt_s5 [4];

	always_comb begin
		for (int d = 0; d < 4; d++) begin
			for (int r = 0; r < 3; r++) begin
				lo_c[d][r] = signed'({1'b0, mn[r][DPR[d]][31:0]});
				hi_c[d][r] = mn[r][DPR[d]][W_MIN-1:32];
				e_c[d][r]  = el[r][DCA[d]];
			end
		end
	end

	always_comb begin
		for (int d = 0; d < 4; d++) begin
			sum_c[d] = '0;
			for (int r = 0; r < 3; r++) begin
				if ((r % 2 == 1) ^ DNEG[d])
					sum_c[d] = sum_c[d] - det_t'(tp_s4[d][r]);
				else
					sum_c[d] = sum_c[d] + det_t'(tp_s4[d][r]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 4; d++) begin
				for (int r = 0; r < 3; r++) begin
					pl_s3[d][r] <= lo_c[d][r] * e_c[d][r];
					ph_s3[d][r] <= hi_c[d][r] * e_c[d][r];
					tp_s4[d][r] <= (tri_t'(ph_s3[d][r]) <<< 32) + tri_t'(pl_s3[d][r]);
				end
				dt_s5[d] <= sum_c[d];
			end
		end
	end

	assign out_v = v_s5;
	assign dt    = dt_s5;

endmodule

>>> design/cc_div.sv
module cc_div import cc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  det_t num [3],
	input  det_t den,
	output logic out_v,
	output quo_t q [3],
	output logic zero
);

	det_t dneg_c;
	det_t nneg_c [3];
	logic v_a;
	logic z_a;
	rem_t d_a;
	rem_t n_a [3];
	logic s_a [3];

	logic vl_s [0:QBITS];
	logic zr_s [0:QBITS];
	rem_t dd_s [0:QBITS];
	rem_t rem_s [0:QBITS][3];
	quo_t quo_s [0:QBITS][3];
	logic sg_s [0:QBITS][3];
	logic ov_s [0:QBITS][3];

	logic v_o;
	logic z_o;
	quo_t q_o [3];
	quo_t res_c [3];

	always_comb begin
		dneg_c = -den;
		for (int l = 0; l < 3; l++)
			nneg_c[l] = -num[l];
	end

	// magnitudes, numerator scaled to the output fraction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_a <= 1'b0;
		else if (en)
			v_a <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_a <= (den == '0);
			d_a <= den[W_DET-1] ? rem_t'($unsigned(dneg_c)) : rem_t'($unsigned(den));
			for (int l = 0; l < 3; l++) begin
				s_a[l] <= num[l][W_DET-1] ^ den[W_DET-1];
				n_a[l] <= (num[l][W_DET-1] ? rem_t'($unsigned(nneg_c[l]))
					: rem_t'($unsigned(num[l]))) << QF;
			end
		end
	end

	// quotient of 2^32 or more saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vl_s[0] <= 1'b0;
		else if (en)
			vl_s[0] <= v_a;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zr_s[0] <= z_a;
			dd_s[0] <= d_a;
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= n_a[l];
				quo_s[0][l] <= '0;
				sg_s[0][l]  <= s_a[l];
				ov_s[0][l]  <= n_a[l] >= (d_a << QBITS);
			end
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QBITS; k++) begin : g_bit
		localparam int SH = QBITS - 1 - k;
		rem_t dk;
		assign dk = dd_s[k] << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vl_s[k+1] <= 1'b0;
			else if (en)
				vl_s[k+1] <= vl_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zr_s[k+1] <= zr_s[k];
				dd_s[k+1] <= dd_s[k];
				for (int l = 0; l < 3; l++) begin
					sg_s[k+1][l] <= sg_s[k][l];
					ov_s[k+1][l] <= ov_s[k][l];
					if (rem_s[k][l] >= dk) begin
						rem_s[k+1][l] <= rem_s[k][l] - dk;
						quo_s[k+1][l] <= quo_s[k][l] | (quo_t'(1) << SH);
					end else begin
						rem_s[k+1][l] <= rem_s[k][l];
						quo_s[k+1][l] <= quo_s[k][l];
					end
				end
			end
		end
	end

	// zero result for a zero divisor, then sign and saturation
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (zr_s[QBITS])
				res_c[l] = '0;
			else if (ov_s[QBITS][l])
				res_c[l] = sg_s[QBITS][l] ? SAT_MIN : SAT_MAX;
			else if (sg_s[QBITS][l])
				res_c[l] = (quo_s[QBITS][l] > SAT_MIN) ? SAT_MIN : -quo_s[QBITS][l];
			else
				res_c[l] = (quo_s[QBITS][l] > SAT_MAX) ? SAT_MAX : quo_s[QBITS][l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_o <= 1'b0;
		else if (en)
			v_o <= vl_s[QBITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_o <= zr_s[QBITS];
			q_o <= res_c;
		end
	end

	assign out_v = v_o;
	assign zero  = z_o;
	assign q     = q_o;

endmodule

>>> bench/camera_center_checker.sv
module camera_center_checker import cc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [31:0] p00,
	input  logic [31:0] p01,
	input  logic [31:0] p02,
	input  logic [31:0] p03,
	input  logic [31:0] p10,
	input  logic [31:0] p11,
	input  logic [31:0] p12,
	input  logic [31:0] p13,
	input  logic [31:0] p20,
	input  logic [31:0] p21,
	input  logic [31:0] p22,
	input  logic [31:0] p23,
	input  logic        center_valid,
	input  logic        center_ready,
	input  logic [31:0] center_x,
	input  logic [31:0] center_y,
	input  logic [31:0] center_z,
	input  logic        at_infinity,
	output int          mismatches,
	output int          pending,
	output int          matrices_in,
	output int          centers_out,
	output int          infinite_seen,
	output int          clipped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        inf;
	} center_t;

	center_t expected_centers [$];

	function automatic wide_t col_det(mat_t m, int a, int b, int c);
		wide_t e [3][3];
		for (int r = 0; r < 3; r++) begin
			e[r][0] = wide_t'(m[r][a]);
			e[r][1] = wide_t'(m[r][b]);
			e[r][2] = wide_t'(m[r][c]);
		end
		return e[0][0] * (e[1][1] * e[2][2] - e[2][1] * e[1][2])
		     - e[1][0] * (e[0][1] * e[2][2] - e[2][1] * e[0][2])
		     + e[2][0] * (e[0][1] * e[1][2] - e[1][1] * e[0][2]);
	endfunction

	function automatic logic [31:0] fixed_ratio(wide_t num, wide_t den, ref logic clip);
		logic signed [131:0] n;
		logic signed [131:0] d;
		logic signed [131:0] q;
		n = num;
		d = den;
		n = n <<< QF;
		q = n / d;
		if (q > 132'sd2147483647) begin
			clip = 1'b1;
			return SAT_MAX;
		end
		if (q < -132'sd2147483648) begin
			clip = 1'b1;
			return SAT_MIN;
		end
		return q[31:0];
	endfunction

	function automatic center_t predict_center(mat_t m, ref logic clip);
		center_t c;
		wide_t x, y, z, t;
		x = col_det(m, 1, 2, 3);
		y = -col_det(m, 0, 2, 3);
		z = col_det(m, 0, 1, 3);
		t = -col_det(m, 0, 1, 2);
		c = '0;
		if (t == 0) begin
			c.inf = 1'b1;
			return c;
		end
		c.x = fixed_ratio(x, t, clip);
		c.y = fixed_ratio(y, t, clip);
		c.z = fixed_ratio(z, t, clip);
		return c;
	endfunction

	always @(posedge clk) begin
		mat_t m;
		center_t c;
		center_t got;
		logic clip;
		if (!arst_n) begin
			mismatches = 0;
			matrices_in = 0;
			centers_out = 0;
			infinite_seen = 0;
			clipped_seen = 0;
			expected_centers.delete();
			pending = 0;
		end else begin
			if (item_valid && item_ready) begin
				m = '{'{p00, p01, p02, p03}, '{p10, p11, p12, p13}, '{p20, p21, p22, p23}};
				clip = 1'b0;
				c = predict_center(m, clip);
				if (c.inf) infinite_seen++;
				if (clip) clipped_seen++;
				expected_centers.push_back(c);
				matrices_in++;
			end
			if (center_valid && center_ready) begin
				got = '{center_x, center_y, center_z, at_infinity};
				centers_out++;
				if (expected_centers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected center word at %0t: %h %h %h %b",
							$time, center_x, center_y, center_z, at_infinity);
				end else begin
					c = expected_centers.pop_front();
					if (got !== c) begin
						mismatches++;
						if (mismatches <= 10)
							$display("center %0d mismatch: exp %h %h %h %b got %h %h %h %b",
								centers_out, c.x, c.y, c.z, c.inf,
								got.x, got.y, got.z, got.inf);
					end
				end
			end
			pending = expected_centers.size();
		end
	end
endmodule

>>> bench/camera_center_from_projection_tb.sv
module camera_center_from_projection_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [31:0] p [12];
	logic        center_valid;
	logic        center_ready = 1'b0;
	logic [31:0] center_x, center_y, center_z;
	logic        at_infinity;
	int          mismatches, pending, matrices_in, centers_out, infinite_seen, clipped_seen;
	int          idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int          hold_left = 0;

	always #5 clk = ~clk;

	initial foreach (p[i]) p[i] = '0;

	camera_center_from_projection dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.p00(p[0]), .p01(p[1]), .p02(p[2]), .p03(p[3]),
		.p10(p[4]), .p11(p[5]), .p12(p[6]), .p13(p[7]),
		.p20(p[8]), .p21(p[9]), .p22(p[10]), .p23(p[11]),
		.center_valid(center_valid), .center_ready(center_ready),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.at_infinity(at_infinity)
	);

	camera_center_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.p00(p[0]), .p01(p[1]), .p02(p[2]), .p03(p[3]),
		.p10(p[4]), .p11(p[5]), .p12(p[6]), .p13(p[7]),
		.p20(p[8]), .p21(p[9]), .p22(p[10]), .p23(p[11]),
		.center_valid(center_valid), .center_ready(center_ready),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.at_infinity(at_infinity),
		.mismatches(mismatches), .pending(pending),
		.matrices_in(matrices_in), .centers_out(centers_out),
		.infinite_seen(infinite_seen), .clipped_seen(clipped_seen)
	);

	// receiver side, with a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				center_ready <= 1'b0;
			end else begin
				center_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_matrix(input logic [31:0] v [12]);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		foreach (v[i]) p[i] <= v[i];
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	function automatic logic [31:0] plain_elem();
		logic [31:0] r;
		r = $urandom;
		return $signed(r) >>> $urandom_range(16, 4);
	endfunction

	task automatic send_random();
		logic [31:0] v [12];
		int kind;
		int src;
		kind = $urandom_range(99);
		src = $urandom_range(2, 1);
		foreach (v[i]) v[i] = plain_elem();
		if (kind < 15) begin
			foreach (v[i]) v[i] = $urandom;
		end else if (kind < 27) begin
			// column 0 copies another column, so the center sits at infinity
			for (int r = 0; r < 3; r++) v[r*4] = v[r*4 + src];
		end else if (kind < 37) begin
			for (int r = 0; r < 3; r++) v[r*4+3] = $urandom;
		end else if (kind < 45) begin
			foreach (v[i]) v[i] = $signed($urandom) >>> 28;
		end
		send_matrix(v);
	endtask

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [31:0] NEG1 = 32'hFFFF_0000;

	initial begin
		logic [31:0] d [12];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		d = '{default: 32'h0};
		send_matrix(d);
		d = '{ONE, 0, 0, 32'h0003_0000, 0, ONE, 0, NEG1, 0, 0, ONE, 32'h0000_8000};
		send_matrix(d);
		d = '{NEG1, 0, 0, 32'h0000_0001, 0, ONE, 0, 0, 0, 0, ONE, 0};
		send_matrix(d);
		d = '{ONE, 0, 0, MAXV, 0, ONE, 0, MINV, 0, 0, ONE, MAXV};
		send_matrix(d);
		d = '{32'h1, 0, 0, MAXV, 0, 32'h1, 0, MINV, 0, 0, 32'h1, 32'h1};
		send_matrix(d);
		d = '{default: MAXV};
		send_matrix(d);
		d = '{default: MINV};
		send_matrix(d);
		d = '{MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MINV, MINV, MAXV, MAXV};
		send_matrix(d);
		d = '{MINV, 0, 0, MINV, 0, MINV, 0, MAXV, 0, 0, MINV, MINV};
		send_matrix(d);
		d = '{MAXV, 0, 0, 32'hFFFF_FFFF, 0, MAXV, 0, 32'h1, 0, 0, MAXV, 0};
		send_matrix(d);
		d = '{32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0, 0, 0,
			32'hFFFF_FFFF, 32'hFFFF_FFFF};
		send_matrix(d);
		d = '{ONE, ONE, 0, ONE, 0, 0, ONE, ONE, ONE, ONE, ONE, 0};
		send_matrix(d);
		d = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hFEDC_BA98,
			32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h8765_4321, 32'h1, 32'h3C3C_3C3C,
			32'hC3C3_C3C3, 32'h0000_FFFF, 32'hFFFF_0000};
		send_matrix(d);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 80 : (ph == 3) ? 36 : 0;
			stall_pct = (ph == 2) ? 80 : (ph == 3) ? 36 : 0;
			for (int n = 0; n < 450; n++) begin
				if (ph == 0 && n == 20) hold_req = 1'b1;
				if (n % 60 == 59) begin
					idle_pct = (idle_pct == 0) ? ((ph == 1) ? 80 : (ph == 3) ? 36 : 0) : 0;
					stall_pct = (stall_pct == 0) ? ((ph == 2) ? 80 : (ph == 3) ? 36 : 0) : 0;
				end
				send_random();
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("%0d matrices in, %0d centers out, %0d at infinity, %0d with clipped coordinates",
			matrices_in, centers_out, infinite_seen, clipped_seen);
		$display("idle and stall phases on both channels, plus one long output hold-off");
		if (mismatches == 0 && pending == 0)
			$display("camera_center_from_projection_tb passed");
		else
			$display("camera_center_from_projection_tb failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("camera_center_from_projection_tb failed");
		$finish;
	end
endmodule
